[hw/rtl/mavg_pkg.sv]
// Shared widths, register indexes and controller/datapath interface types.
`default_nettype none

package mavg_pkg;

    localparam int DATA_W               = 16;  // sample and filtered value
    localparam int CNT_W                = 16;  // sample count and warm-up count
    localparam int WIN_W                = 6;   // window length register
    localparam int S_TDATA_W            = 32;
    localparam int M_TDATA_W            = 16;
    localparam int CFG_IDX_W            = 1;
    localparam int CFG_DATA_W           = 16;
    localparam int WINDOW_DEPTH_DEFAULT = 32;
    localparam int WINDOW_LENGTH_RESET  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT  = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch request, read ring entry
        logic update;    // update running sum, write ring, advance index
        logic div_load;  // load divider with |sum|
        logic div_step;  // one restoring divide step
        logic out_load;  // load output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } sts_t;

endpackage

`default_nettype wire

[hw/rtl/mavg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mavg_ctrl.sv]
// Sequencer: request accept, ring update, divide iterations, output load.
`default_nettype none

module mavg_ctrl #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire mavg_pkg::sts_t sts,
    output mavg_pkg::cmd_t     cmd
);

    import mavg_pkg::*;

    localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = STEP_W'(SUM_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_OUT:
            begin
                cmd.out_load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mavg_datapath.sv]
// Ring, running sum, restoring divider, config registers and output register.
`default_nettype none

module mavg_datapath #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mavg_pkg::cmd_t                  cmd,
    output mavg_pkg::sts_t                       sts,
    input  wire logic [mavg_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic [mavg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mavg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mavg_pkg::M_TDATA_W-1:0]  m_tdata
);

    import mavg_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = DATA_W + IDX_W;
    localparam int CMP_W = (LEN_W > WIN_W) ? LEN_W : WIN_W;
    localparam logic [LEN_W-1:0] LEN_RESET =
        LEN_W'((WINDOW_DEPTH < WINDOW_LENGTH_RESET) ? WINDOW_DEPTH : WINDOW_LENGTH_RESET);

    // request payload
    logic [DATA_W-1:0] sample_reg;
    logic [CNT_W-1:0]  count_reg;

    // filter state
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]       ring_rdata;
    logic [DATA_W-1:0]       old_sample;

    // configuration
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] warm_reg;
    logic [CMP_W-1:0] win_ext;
    logic [CMP_W-1:0] depth_c;
    logic             win_wr;
    logic             warm_wr;

    // divider
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quot_reg, quot_next;
    logic             neg_reg;
    logic [LEN_W:0]   trial;
    logic             trial_ge;
    logic [SUM_W-1:0] sum_abs;
    logic [SUM_W-1:0] avg;
    logic [LEN_W-1:0] idx_inc;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg, m_data_next;

    mavg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (idx_reg),
        .wdata (sample_reg),
        .re    (cmd.accept),
        .raddr (idx_reg),
        .rdata (ring_rdata)
    );

    assign win_wr  = cfg_valid && (cfg_index == REG_WINDOW_LENGTH);
    assign warm_wr = cfg_valid && (cfg_index == REG_WARMUP_COUNT);

    // zero means one, anything above the ring depth saturates
    assign win_ext = CMP_W'(cfg_data[WIN_W-1:0]);
    assign depth_c = CMP_W'(WINDOW_DEPTH);
    always_comb
    begin
        if (win_ext == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (win_ext > depth_c)
        begin
            len_next = LEN_W'(depth_c);
        end
        else
        begin
            len_next = LEN_W'(win_ext);
        end
    end

    // never-written entries read as zero
    assign old_sample = valid_reg[idx_reg] ? ring_rdata : '0;
    assign sum_next   = sum_reg
                      - {{(SUM_W-DATA_W){old_sample[DATA_W-1]}}, old_sample}
                      + {{(SUM_W-DATA_W){sample_reg[DATA_W-1]}}, sample_reg};
    assign idx_inc    = LEN_W'(idx_reg) + LEN_W'(1);
    assign idx_next   = (idx_inc >= len_reg) ? '0 : IDX_W'(idx_inc);

    assign sum_abs   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
    assign trial     = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_ge  = trial >= {1'b0, len_reg};
    assign rem_next  = trial_ge ? LEN_W'(trial - {1'b0, len_reg}) : trial[LEN_W-1:0];
    assign quot_next = {quot_reg[SUM_W-2:0], trial_ge};

    assign avg         = neg_reg ? (~quot_reg + SUM_W'(1)) : quot_reg;
    assign m_data_next = (count_reg >= warm_reg) ? avg[DATA_W-1:0] : sample_reg;

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            valid_reg   <= '0;
            len_reg     <= LEN_RESET;
            warm_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (win_wr)
            begin
                len_reg   <= len_next;
                idx_reg   <= '0;
                sum_reg   <= '0;
                valid_reg <= '0;
            end
            else if (cmd.update)
            begin
                idx_reg            <= idx_next;
                sum_reg            <= sum_next;
                valid_reg[idx_reg] <= 1'b1;
            end
            if (warm_wr)
            begin
                warm_reg <= cfg_data[CNT_W-1:0];
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= s_tdata[DATA_W-1:0];
            count_reg  <= s_tdata[DATA_W +: CNT_W];
        end
        if (cmd.div_load)
        begin
            quot_reg <= sum_abs;
            rem_reg  <= '0;
            neg_reg  <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        if (cmd.out_load)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/moving_average_filter.sv]
// Boxcar moving-average filter, top level.
//
// Input stream (s_t*): one request per sample, s_tdata = {sample_count, sample},
// sample (signed) in bits 15:0. Output stream (m_t*): one filtered value per
// request. Configuration channel (cfg_*): cfg_index 0 writes window_length
// (bits 5:0), cfg_index 1 writes warmup_count (bits 15:0); always ready.
// Writing window_length clears the ring, running sum and write index. Write
// configuration only with no request in flight.
//
// A request is latched, updates the ring and running sum, loads the divider
// with |sum|, runs SUM_W = 16 + clog2(WINDOW_DEPTH) restoring divide steps
// and is loaded into the output register; the divider retires one quotient
// bit per cycle. The next request is taken only once that load is done.
// Reset clears the ring (per-entry valid bits), sum, index and output valid;
// window_length returns to 32, warmup_count to 0.
// If the receiver stalls, the result waits in the output register; the next
// request is still taken and computed, then held until that register drains.
`default_nettype none

module moving_average_filter #(
    parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mavg_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample, [31:16] sample_count
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mavg_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] filtered_value
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mavg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mavg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mavg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    mavg_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mavg_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/mavg_checker.sv]
// Port-level checks for the moving-average filter, bound to the top level.
`default_nettype none

module mavg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mavg_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result is held
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output request dropped or changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in flight");

    // no result can appear right behind an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result produced before the divide finished");

    // while the input side is busy, it stays busy for the next cycle too
    a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 !s_tready)
        else $error("input ready too soon after accept");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/tb_moving_average_filter.sv]
// Self-checking testbench for the boxcar moving-average filter.
`default_nettype none

module tb_moving_average_filter;

    import mavg_pkg::*;

    localparam int DEPTH        = WINDOW_DEPTH_DEFAULT;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int SUM_W        = DATA_W + SLOT_W;   // exact sum of a full ring
    localparam int ITEM_TARGET  = 1700;              // requests, directed part included
    localparam int STALL_LIMIT  = 2000;              // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 40;                // margin for the last result to drain

    // Directed table: one row is either a register write or a sample request.
    typedef enum logic [0:0] {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;  // unused on sample rows
        logic [CFG_DATA_W-1:0]  word;     // register data, or the sample
        logic [CNT_W-1:0]       count;
        logic                   typed;    // want holds a hand-worked result
        logic [DATA_W-1:0]      want;
    } stim_row_t;

    localparam int N_ROWS = 23;

    // Reset state: window 32, warm-up 0, so averaging from the first request.
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        // 32767/32 truncates to 1023
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF,   16'd0,     1'b1, 16'd1023},
        // sum of -1 truncates toward zero, not down to -1
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000,   16'd0,     1'b1, 16'd0},
        // window of zero behaves as a window of one
        '{ROW_WRITE,  REG_WINDOW_LENGTH, 16'd0,      16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h8000,   16'd0,     1'b1, 16'h8000},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF,   16'hFFFF,  1'b1, 16'h7FFF},
        // 63 in the low bits saturates to the full depth; upper bits ignored
        '{ROW_WRITE,  REG_WINDOW_LENGTH, 16'hFFFF,   16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF,   16'd0,     1'b1, 16'd1023},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF,   16'd0,     1'b1, 16'd2047},
        // window of two: negative sums truncate toward zero, index wraps
        '{ROW_WRITE,  REG_WINDOW_LENGTH, 16'd2,      16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, -16'sd3,    16'd0,     1'b1, -16'sd1},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd0,      16'd0,     1'b1, -16'sd1},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd4,      16'd0,     1'b1, 16'd2},
        // largest warm-up: raw sample just below it, average at it
        '{ROW_WRITE,  REG_WARMUP_COUNT,  16'hFFFF,   16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd100,    16'hFFFE,  1'b1, 16'd100},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd200,    16'hFFFF,  1'b1, 16'd150},
        // compare is unsigned: 0x7FFF stays below 0x8000
        '{ROW_WRITE,  REG_WARMUP_COUNT,  16'h8000,   16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, -16'sd1,    16'h7FFF,  1'b1, -16'sd1},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd1,      16'h8000,  1'b0, 16'd0},
        '{ROW_WRITE,  REG_WINDOW_LENGTH, 16'd32,     16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'h5555,   16'hAAAA,  1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'hAAAA,   16'h5555,  1'b0, 16'd0},
        '{ROW_SAMPLE, REG_WINDOW_LENGTH, 16'd0,      16'd0,     1'b0, 16'd0},
        '{ROW_WRITE,  REG_WARMUP_COUNT,  16'd0,      16'd0,     1'b0, 16'd0}
    };

    // DUT inputs, all known from time zero; reset held low at the start.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_ready;

    // Shadow copy of the filter state and registers.
    logic signed [DATA_W-1:0] window_samples [DEPTH];
    logic signed [SUM_W-1:0]  window_sum;
    logic [SLOT_W-1:0]        window_slot;
    logic [WIN_W-1:0]         window_reg = WIN_W'(WINDOW_LENGTH_RESET);
    logic [CNT_W-1:0]         warmup_reg = '0;

    logic [DATA_W-1:0] expected_filtered [$];   // oldest first

    int  mismatches   = 0;
    int  idle_cycles  = 0;
    int  requests_out = 0;
    bit  source_quiet = 1'b0;   // no gaps between requests this phase
    bit  sink_quiet   = 1'b0;   // no back-pressure this phase

    moving_average_filter #(
        .WINDOW_DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] sample, [31:16] sample_count
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] filtered_value
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Empties the ring, as at reset and on every window_length write.
    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++)
        begin
            window_samples[i] = '0;
        end
        window_sum  = '0;
        window_slot = '0;
    endfunction

    // One request through the shadow filter; returns the value the block should emit.
    function automatic logic [DATA_W-1:0] boxcar_average(input logic signed [DATA_W-1:0] smp,
                                                         input logic [CNT_W-1:0] cnt);
        int span;
        int slot;
        int quotient;
        span = int'(window_reg);
        if (span == 0)
            span = 1;
        if (span > DEPTH)
            span = DEPTH;
        slot = int'(window_slot);
        if (slot >= span)
            slot = 0;
        // oldest entry out, new sample in; sum stays exact
        window_sum           = window_sum - window_samples[slot] + smp;
        window_samples[slot] = smp;
        window_slot          = (slot + 1 >= span) ? '0 : SLOT_W'(slot + 1);
        // SV integer divide truncates toward zero
        quotient = int'(window_sum) / span;
        return (cnt >= warmup_reg) ? quotient[DATA_W-1:0] : smp;
    endfunction

    // Register write; more keeps cfg_valid up for a write that follows straight on.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] word,
                                  input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (!more)
            cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_LENGTH)
        begin
            window_reg = word[WIN_W-1:0];
            clear_window();
        end
        else
        begin
            warmup_reg = word;
        end
    endtask

    // One sample request, after a random gap; typed overrides the shadow result.
    task automatic send_sample(input logic [DATA_W-1:0] smp, input logic [CNT_W-1:0] cnt,
                               input bit typed, input logic [DATA_W-1:0] want);
        int unsigned gap;
        logic [DATA_W-1:0] predicted;
        gap = source_quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cnt, smp};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted = boxcar_average(smp, cnt);
        expected_filtered.push_back(typed ? want : predicted);
        requests_out++;
    endtask

    // Block is idle once every request has produced its one result.
    task automatic wait_idle();
        if (s_tvalid !== 1'b0)
            s_tvalid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_window_word();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);   // upper bits are noise the block must drop
        case ($urandom_range(0, 9))
            0:       word[WIN_W-1:0] = '0;
            1:       word[WIN_W-1:0] = WIN_W'(1);
            2:       word[WIN_W-1:0] = WIN_W'(DEPTH);
            3:       word[WIN_W-1:0] = WIN_W'($urandom_range(DEPTH + 1, 63));
            default: word[WIN_W-1:0] = WIN_W'($urandom_range(1, DEPTH));
        endcase
        return word;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_warmup();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 100));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Result side: random back-pressure, each result checked against the oldest expectation.
    initial
    begin : sink
        int unsigned stall;
        logic [DATA_W-1:0] want;
        forever
        begin
            stall = sink_quiet ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            if (expected_filtered.size() == 0)
            begin
                $display("%0t: unexpected result, filtered_value %0d",
                         $time, $signed(m_tdata));
                mismatches++;
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: filtered_value expected %0d, actual %0d",
                             $time, $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned phase_len;
        int unsigned sample_style;
        int unsigned count_style;
        logic [CNT_W-1:0]  next_count;
        logic [DATA_W-1:0] smp;
        logic [CNT_W-1:0]  cnt;
        bit rail_high;

        clear_window();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; writes only with nothing in flight
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
            begin
                wait_idle();
                write_register(DIRECTED[r].reg_idx, DIRECTED[r].word, 1'b0);
            end
            else
            begin
                send_sample(DIRECTED[r].word, DIRECTED[r].count,
                            DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // random phases: fresh settings, then a run of requests in one style
        while (requests_out < ITEM_TARGET)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: ;   // keep settings, ring carries over
                1: write_register(REG_WINDOW_LENGTH, draw_window_word(), 1'b0);
                2: write_register(REG_WARMUP_COUNT, draw_warmup(), 1'b0);
                default:
                begin
                    write_register(REG_WINDOW_LENGTH, draw_window_word(), 1'b1);
                    write_register(REG_WARMUP_COUNT, draw_warmup(), 1'b0);
                end
            endcase

            source_quiet = ($urandom_range(0, 4) == 0);
            sink_quiet   = ($urandom_range(0, 4) == 0);
            phase_len    = $urandom_range(8, 80);
            sample_style = $urandom_range(0, 4);
            count_style  = $urandom_range(0, 2);
            // counter starts a little short of the warm-up so the switch-over is crossed
            next_count   = warmup_reg - CNT_W'($urandom_range(0, 40));
            rail_high    = ($urandom_range(0, 1) == 1);
            smp          = DATA_W'($urandom);

            repeat (phase_len)
            begin
                case (sample_style)
                    0: smp = DATA_W'($urandom);
                    1:
                    begin
                        // full-scale rails, long runs drive the sum to its limits
                        if ($urandom_range(0, 9) == 0)
                            rail_high = ~rail_high;
                        smp = rail_high ? 16'h7FFF : 16'h8000;
                    end
                    2: smp = DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
                    3: smp = $urandom_range(0, 1) ? 16'h7FF0 | DATA_W'($urandom_range(0, 15))
                                                  : 16'h8000 | DATA_W'($urandom_range(0, 15));
                    default: ;   // constant run at a random level
                endcase
                case (count_style)
                    0:
                    begin
                        cnt        = next_count;
                        next_count = next_count + 1'b1;
                    end
                    1: cnt = CNT_W'($urandom);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       cnt = '0;
                            1:       cnt = '1;
                            2:       cnt = warmup_reg;
                            default: cnt = warmup_reg - 1'b1;
                        endcase
                    end
                endcase
                send_sample(smp, cnt, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_filtered.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
